[rtl/sha256_pkg.sv]
// Package for the SHA-256 digest unit: round constants, initial chain values,
// the job type passed from the front end to the compression core, and helpers.
// No dependencies.
package sha256_pkg;

	localparam int BLOCK_BITS = 512;

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_CHAIN [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;

	typedef struct packed {
		logic                  last;
		logic [BLOCK_BITS-1:0] blk;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		ror32 = (x >> n) | (x << (32 - n));
	endfunction

endpackage

[rtl/sha256_message_digest_unit.sv]
// SHA-256 digest unit: byte-serial input, one 256-bit digest per message.
// Throughput: one byte per cycle into the packer while data_stall is low; each 64-byte
// block passes through the core as a load, 64 rounds and a chain add.
// After the end item, one or two padded blocks, plus any blocks still queued, are
// hashed before the digest appears. A two-entry queue decouples sides.
// Reset (arst_n low, asynchronous) empties the queue and reloads the initial chain.
module sha256_message_digest_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word_0,
	output logic [31:0] digest_word_1,
	output logic [31:0] digest_word_2,
	output logic [31:0] digest_word_3,
	output logic [31:0] digest_word_4,
	output logic [31:0] digest_word_5,
	output logic [31:0] digest_word_6,
	output logic [31:0] digest_word_7
);
	import sha256_pkg::*;

	fifo_stat_t  q_stat;
	job_t        push_job;
	job_t        rd_job;
	logic        push;
	logic        pop;
	logic [31:0] dig [0:7];

	sha256_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_valid     (data_valid),
		.data_stall     (data_stall),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.q_stat         (q_stat),
		.push           (push),
		.push_job       (push_job)
	);

	sha256_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.rd_job (rd_job),
		.stat   (q_stat)
	);

	sha256_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.rd_job       (rd_job),
		.pop          (pop),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.dig          (dig)
	);

	assign digest_word_0 = dig[0];
	assign digest_word_1 = dig[1];
	assign digest_word_2 = dig[2];
	assign digest_word_3 = dig[3];
	assign digest_word_4 = dig[4];
	assign digest_word_5 = dig[5];
	assign digest_word_6 = dig[6];
	assign digest_word_7 = dig[7];
endmodule

[rtl/sha256_fifo.sv]
// Two-entry job queue between the front end and the compression core.
// Depends on sha256_pkg.
module sha256_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  sha256_pkg::job_t       wr_job,
	input  logic                   pop,
	output sha256_pkg::job_t       rd_job,
	output sha256_pkg::fifo_stat_t stat
);
	import sha256_pkg::*;

	job_t       mem_q [0:1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign rd_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

[rtl/sha256_front.sv]
// Front end: packs message bytes into 64-byte blocks, applies padding and the
// bit length, and pushes complete blocks as jobs. Depends on sha256_pkg.
module sha256_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   data_valid,
	output logic                   data_stall,
	input  logic [7:0]             data_byte,
	input  logic                   byte_present,
	input  logic                   end_of_message,
	input  sha256_pkg::fifo_stat_t q_stat,
	output logic                   push,
	output sha256_pkg::job_t       push_job
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_PAD1 = 3'b010,
		F_PAD2 = 3'b100
	} fstate_t;

	fstate_t                st_q;
	logic [5:0]             fill_q;
	logic [63:0]            bits_q;
	logic [BLOCK_BITS-1:0]  buf_q;
	logic [BLOCK_BITS-1:0]  merged;
	logic [BLOCK_BITS-1:0]  padded;
	logic                   take;
	logic                   len_here;

	assign data_stall = (st_q != F_IDLE) || q_stat.full;
	assign take       = data_valid && !data_stall;
	assign len_here   = (st_q == F_PAD2) || (fill_q < LEN_OFFSET);

	always_comb begin
		merged = buf_q;
		for (int i = 0; i < 64; i++) begin
			if (fill_q == 6'(i)) begin
				merged[BLOCK_BITS-1-8*i -: 8] = data_byte;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 64; i++) begin
			if (st_q == F_PAD1 && 6'(i) < fill_q) begin
				padded[BLOCK_BITS-1-8*i -: 8] = buf_q[BLOCK_BITS-1-8*i -: 8];
			end else if (st_q == F_PAD1 && 6'(i) == fill_q) begin
				padded[BLOCK_BITS-1-8*i -: 8] = PAD_BYTE;
			end else begin
				padded[BLOCK_BITS-1-8*i -: 8] = 8'h00;
			end
		end
		if (len_here) begin
			padded[63:0] = bits_q;
		end
	end

	always_comb begin
		push     = 1'b0;
		push_job = '{last: 1'b0, blk: merged};
		case (st_q)
			F_IDLE: begin
				push = take && byte_present && (fill_q == 6'd63);
			end
			F_PAD1, F_PAD2: begin
				push     = !q_stat.full;
				push_job = '{last: len_here, blk: padded};
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take && byte_present) begin
			buf_q <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			fill_q <= 6'd0;
			bits_q <= 64'd0;
		end else begin
			case (st_q)
				F_IDLE: begin
					if (take) begin
						if (byte_present) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
						end
						if (end_of_message) begin
							st_q <= F_PAD1;
						end
					end
				end
				F_PAD1: begin
					if (!q_stat.full) begin
						if (len_here) begin
							st_q   <= F_IDLE;
							fill_q <= 6'd0;
							bits_q <= 64'd0;
						end else begin
							st_q <= F_PAD2;
						end
					end
				end
				F_PAD2: begin
					if (!q_stat.full) begin
						st_q   <= F_IDLE;
						fill_q <= 6'd0;
						bits_q <= 64'd0;
					end
				end
				default: begin
					st_q <= F_IDLE;
				end
			endcase
		end
	end
endmodule

[rtl/sha256_core.sv]
// Compression core: one round per cycle over a 16-word schedule window,
// chain update, and the registered digest output. Depends on sha256_pkg.
module sha256_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha256_pkg::fifo_stat_t q_stat,
	input  sha256_pkg::job_t       rd_job,
	output logic                   pop,
	output logic                   digest_valid,
	input  logic                   digest_stall,
	output logic [31:0]            dig [0:7]
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_FIN  = 3'b100
	} cstate_t;

	cstate_t     st_q;
	logic [5:0]  round_q;
	logic        last_q;
	logic [31:0] v_q     [0:7];
	logic [31:0] w_q     [0:15];
	logic [31:0] chain_q [0:7];
	logic [31:0] dig_q   [0:7];
	logic [31:0] t1, t2, s0, s1, w_new;
	logic        out_free;

	assign pop      = (st_q == C_IDLE) && !q_stat.empty;
	assign out_free = !digest_valid || !digest_stall;
	assign dig      = dig_q;

	always_comb begin
		s1 = ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25);
		s0 = ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22);
		t1 = v_q[7] + s1 + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[round_q] + w_q[0];
		t2 = s0 + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = w_q[0] + w_q[9]
			+ (ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3))
			+ (ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10));
	end

	always_ff @(posedge clk) begin
		case (st_q)
			C_IDLE: begin
				if (pop) begin
					for (int i = 0; i < 16; i++) begin
						w_q[i] <= rd_job.blk[BLOCK_BITS-1-32*i -: 32];
					end
					for (int i = 0; i < 8; i++) begin
						v_q[i] <= chain_q[i];
					end
				end
			end
			C_RUN: begin
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[15] <= w_new;
				v_q[7]  <= v_q[6];
				v_q[6]  <= v_q[5];
				v_q[5]  <= v_q[4];
				v_q[4]  <= v_q[3] + t1;
				v_q[3]  <= v_q[2];
				v_q[2]  <= v_q[1];
				v_q[1]  <= v_q[0];
				v_q[0]  <= t1 + t2;
			end
			C_FIN: begin
				if (last_q && out_free) begin
					for (int i = 0; i < 8; i++) begin
						dig_q[i] <= chain_q[i] + v_q[i];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= C_IDLE;
			round_q      <= 6'd0;
			last_q       <= 1'b0;
			digest_valid <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_CHAIN[i];
			end
		end else begin
			if ((st_q == C_FIN) && last_q && out_free) begin
				digest_valid <= 1'b1;
			end else if (!digest_stall) begin
				digest_valid <= 1'b0;
			end
			case (st_q)
				C_IDLE: begin
					if (pop) begin
						st_q    <= C_RUN;
						round_q <= 6'd0;
						last_q  <= rd_job.last;
					end
				end
				C_RUN: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						st_q <= C_FIN;
					end
				end
				C_FIN: begin
					if (!last_q) begin
						for (int i = 0; i < 8; i++) begin
							chain_q[i] <= chain_q[i] + v_q[i];
						end
						st_q <= C_IDLE;
					end else if (out_free) begin
						for (int i = 0; i < 8; i++) begin
							chain_q[i] <= INIT_CHAIN[i];
						end
						st_q <= C_IDLE;
					end
				end
				default: begin
					st_q <= C_IDLE;
				end
			endcase
		end
	end
endmodule
